### sv/qrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and defaults for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  // Default coefficient format: Q16.16
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Result case codes
  typedef enum logic [2:0] {
    RC_INDET    = 3'd0,
    RC_NONE     = 3'd1,
    RC_LINEAR   = 3'd2,
    RC_TWO_REAL = 3'd3,
    RC_DOUBLE   = 3'd4,
    RC_COMPLEX  = 3'd5
  } root_case_e;

  // Per-beat control that rides along the divider pipeline
  typedef struct packed {
    root_case_e rc;
    logic       use1;
    logic       use2;
    logic       neg1;
    logic       neg2;
  } qrs_info_t;

endpackage

### sv/qrs_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined integer square root, floor, one result bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt #(
  parameter int IW = 65,
  parameter int RW = 33,
  parameter int TW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [IW-1:0] rad_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [RW-1:0] root_o,
  output logic [TW-1:0] tag_o
);

  localparam int RMW = 2 * RW;

  logic [RW-1:0]  vld_q;
  logic [RMW-1:0] rem_q  [RW];
  logic [RW-1:0]  root_q [RW];
  logic [TW-1:0]  tag_q  [RW];

  for (genvar g = 0; g < RW; g++) begin : g_stage
    localparam int B = RW - 1 - g;
    logic [RMW-1:0] rem_in, trial, rem_d;
    logic [RW-1:0]  root_in, root_d;
    logic [TW-1:0]  tag_in;
    logic           vld_in;

    if (g == 0) begin : g_first
      assign rem_in  = RMW'(rad_i);
      assign root_in = '0;
      assign tag_in  = tag_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign tag_in  = tag_q[g-1];
      assign vld_in  = vld_q[g-1];
    end

    // try to set this bit: (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
    always_comb begin
      trial  = (RMW'(root_in) << (B + 1)) | (RMW'(1) << (2 * B));
      rem_d  = rem_in;
      root_d = root_in;
      if (rem_in >= trial) begin
        rem_d     = rem_in - trial;
        root_d[B] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g]  <= rem_d;
      root_q[g] <= root_d;
      tag_q[g]  <= tag_in;
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign tag_o   = tag_q[RW-1];

endmodule

### sv/qrs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_div
// Two-lane pipelined restoring divider with a shared divisor, one quotient
// bit per stage and lane.
// ----------------------------------------------------------------------------
module qrs_div
  import qrs_pkg::*;
#(
  parameter int NW = 50,
  parameter int DW = 33
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] num1_i,
  input  logic [NW-1:0] num2_i,
  input  logic [DW-1:0] den_i,
  input  qrs_info_t     info_i,
  output logic          valid_o,
  output logic [NW-1:0] quo1_o,
  output logic [NW-1:0] quo2_o,
  output qrs_info_t     info_o
);

  logic [NW-1:0] vld_q;
  logic [NW-1:0] num_q  [NW][2];
  logic [NW-1:0] quo_q  [NW][2];
  logic [DW-1:0] rem_q  [NW][2];
  logic [DW-1:0] den_q  [NW];
  qrs_info_t     info_q [NW];

  for (genvar g = 0; g < NW; g++) begin : g_stage
    localparam int B = NW - 1 - g;
    logic [NW-1:0] num_in [2];
    logic [NW-1:0] quo_in [2];
    logic [DW-1:0] rem_in [2];
    logic [NW-1:0] quo_d  [2];
    logic [DW-1:0] rem_d  [2];
    logic [DW:0]   remx   [2];
    logic [DW-1:0] den_in;
    qrs_info_t     info_in;
    logic          vld_in;

    if (g == 0) begin : g_first
      assign num_in[0] = num1_i;
      assign num_in[1] = num2_i;
      assign quo_in[0] = '0;
      assign quo_in[1] = '0;
      assign rem_in[0] = '0;
      assign rem_in[1] = '0;
      assign den_in    = den_i;
      assign info_in   = info_i;
      assign vld_in    = valid_i;
    end else begin : g_next
      assign num_in[0] = num_q[g-1][0];
      assign num_in[1] = num_q[g-1][1];
      assign quo_in[0] = quo_q[g-1][0];
      assign quo_in[1] = quo_q[g-1][1];
      assign rem_in[0] = rem_q[g-1][0];
      assign rem_in[1] = rem_q[g-1][1];
      assign den_in    = den_q[g-1];
      assign info_in   = info_q[g-1];
      assign vld_in    = vld_q[g-1];
    end

    // shift in the next numerator bit, subtract when it fits
    always_comb begin
      for (int l = 0; l < 2; l++) begin
        remx[l]  = {rem_in[l], num_in[l][B]};
        quo_d[l] = quo_in[l];
        rem_d[l] = DW'(remx[l]);
        if (remx[l] >= {1'b0, den_in}) begin
          rem_d[l]    = DW'(remx[l] - {1'b0, den_in});
          quo_d[l][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      for (int l = 0; l < 2; l++) begin
        num_q[g][l] <= num_in[l];
        quo_q[g][l] <= quo_d[l];
        rem_q[g][l] <= rem_d[l];
      end
      den_q[g]  <= den_in;
      info_q[g] <= info_in;
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quo1_o  = quo_q[NW-1][0];
  assign quo2_o  = quo_q[NW-1][1];
  assign info_o  = info_q[NW-1];

endmodule

### sv/quadratic_root_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Roots of a*x^2 + b*x + c = 0 on signed fixed-point coefficients, with
// exact discriminant, floor square root and truncating divisions.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+------------------
//  command  | coef_a_i, coef_b_i, coef_c_i              | start_i, busy_o
//  result   | root_case_o, first_value_o,               | done_o (strobe)
//           | second_value_o, saturated_o               |
//
// One coefficient set is taken every cycle; busy_o stays low.
// Each set passes the capture, sign, product, discriminant, bit-per-stage
// root, numerator, bit-per-stage divider, output registers; Q16.16 default.
// Results leave in order, one cycle each under done_o; there is no stall.
// Reset clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
module quadratic_root_solver
  import qrs_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [DATA_WIDTH-1:0] coef_a_i,
  input  logic [DATA_WIDTH-1:0] coef_b_i,
  input  logic [DATA_WIDTH-1:0] coef_c_i,
  output logic                  done_o,
  output logic [2:0]            root_case_o,
  output logic [DATA_WIDTH-1:0] first_value_o,
  output logic [DATA_WIDTH-1:0] second_value_o,
  output logic                  saturated_o
);

  localparam int W   = DATA_WIDTH;
  localparam int DMW = 2 * W + 1;           // discriminant magnitude
  localparam int SW  = W + 1;               // square root
  localparam int NM  = W + 2;               // numerator magnitude
  localparam int NW  = NM + FRAC_BITS;      // scaled numerator / quotient
  localparam int DNW = W + 1;               // divisor
  localparam int TW  = 3 + 3 + 3 * W;       // sqrt side data

  assign busy_o = 1'b0;

  // Stage 1: capture the beat
  logic         vld1_q;
  logic [W-1:0] a1_q, b1_q, c1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q <= coef_a_i;
    b1_q <= coef_b_i;
    c1_q <= coef_c_i;
  end

  // Stage 2: split into sign and magnitude
  logic         vld2_q, na2_q, nb2_q, nc2_q;
  logic [W-1:0] ma2_q, mb2_q, mc2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    na2_q <= a1_q[W-1];
    nb2_q <= b1_q[W-1];
    nc2_q <= c1_q[W-1];
    ma2_q <= a1_q[W-1] ? W'(-a1_q) : a1_q;
    mb2_q <= b1_q[W-1] ? W'(-b1_q) : b1_q;
    mc2_q <= c1_q[W-1] ? W'(-c1_q) : c1_q;
  end

  // Stage 3: b*b and a*c
  logic           vld3_q, na3_q, nb3_q, nc3_q;
  logic [W-1:0]   ma3_q, mb3_q, mc3_q;
  logic [2*W-1:0] bsq3_q, ac3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
    end else begin
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bsq3_q <= (2*W)'(mb2_q) * (2*W)'(mb2_q);
    ac3_q  <= (2*W)'(ma2_q) * (2*W)'(mc2_q);
    na3_q  <= na2_q;
    nb3_q  <= nb2_q;
    nc3_q  <= nc2_q;
    ma3_q  <= ma2_q;
    mb3_q  <= mb2_q;
    mc3_q  <= mc2_q;
  end

  // Stage 4: discriminant as sign and magnitude
  logic [2*W+1:0] bsq_x, p_x, dsum;
  logic           ac_pos, dneg;

  always_comb begin
    bsq_x  = (2*W+2)'(bsq3_q);
    p_x    = {ac3_q, 2'b00};
    ac_pos = (na3_q == nc3_q) && (mc3_q != '0);
    dneg   = 1'b0;
    if (!ac_pos) begin
      dsum = bsq_x + p_x;
    end else if (bsq_x >= p_x) begin
      dsum = bsq_x - p_x;
    end else begin
      dsum = p_x - bsq_x;
      dneg = 1'b1;
    end
  end

  logic           vld4_q, na4_q, nb4_q, nc4_q, dneg4_q;
  logic [W-1:0]   ma4_q, mb4_q, mc4_q;
  logic [DMW-1:0] dmag4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld4_q <= 1'b0;
    end else begin
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dmag4_q <= DMW'(dsum);
    dneg4_q <= dneg;
    na4_q   <= na3_q;
    nb4_q   <= nb3_q;
    nc4_q   <= nc3_q;
    ma4_q   <= ma3_q;
    mb4_q   <= mb3_q;
    mc4_q   <= mc3_q;
  end

  // Classify the equation
  root_case_e rc4;

  always_comb begin
    if (ma4_q == '0) begin
      if (mb4_q == '0) begin
        rc4 = (mc4_q == '0) ? RC_INDET : RC_NONE;
      end else begin
        rc4 = RC_LINEAR;
      end
    end else if (dmag4_q == '0) begin
      rc4 = RC_DOUBLE;
    end else if (dneg4_q) begin
      rc4 = RC_COMPLEX;
    end else begin
      rc4 = RC_TWO_REAL;
    end
  end

  // Square root of the discriminant magnitude
  logic          sq_vld;
  logic [SW-1:0] sq_root;
  logic [TW-1:0] sq_tag;

  qrs_sqrt #(
    .IW (DMW),
    .RW (SW),
    .TW (TW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld4_q),
    .rad_i   (dmag4_q),
    .tag_i   ({rc4, na4_q, nb4_q, nc4_q, ma4_q, mb4_q, mc4_q}),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .tag_o   (sq_tag)
  );

  // Stage 5: pick numerators, divisor and signs per case
  root_case_e   rc5;
  logic         na5, nb5, nc5;
  logic [W-1:0] ma5, mb5, mc5;
  logic signed [NM:0] mbs, sqs, n1, n2;
  logic [NM-1:0] n1_mag, n2_mag, num1, num2;
  logic [DNW-1:0] den2a, den;
  qrs_info_t      info5;

  always_comb begin
    rc5    = root_case_e'(sq_tag[TW-1 -: 3]);
    na5    = sq_tag[3*W+2];
    nb5    = sq_tag[3*W+1];
    nc5    = sq_tag[3*W];
    ma5    = sq_tag[3*W-1 -: W];
    mb5    = sq_tag[2*W-1 -: W];
    mc5    = sq_tag[W-1:0];
    mbs    = nb5 ? signed'((NM+1)'(mb5)) : -signed'((NM+1)'(mb5));
    sqs    = signed'((NM+1)'(sq_root));
    n1     = mbs + sqs;
    n2     = mbs - sqs;
    n1_mag = n1[NM] ? NM'(-n1) : NM'(n1);
    n2_mag = n2[NM] ? NM'(-n2) : NM'(n2);
    den2a  = {ma5, 1'b0};

    num1       = '0;
    num2       = '0;
    den        = den2a;
    info5.rc   = rc5;
    info5.use1 = 1'b0;
    info5.use2 = 1'b0;
    info5.neg1 = 1'b0;
    info5.neg2 = 1'b0;
    case (rc5)
      RC_LINEAR: begin
        num1       = NM'(mc5);
        den        = DNW'(mb5);
        info5.use1 = 1'b1;
        info5.neg1 = (nc5 == nb5) && (mc5 != '0);
      end
      RC_DOUBLE: begin
        num1       = NM'(mb5);
        info5.use1 = 1'b1;
        info5.neg1 = (nb5 == na5) && (mb5 != '0);
      end
      RC_COMPLEX: begin
        num1       = NM'(mb5);
        num2       = NM'(sq_root);
        info5.use1 = 1'b1;
        info5.use2 = 1'b1;
        info5.neg1 = (nb5 == na5) && (mb5 != '0);
      end
      RC_TWO_REAL: begin
        num1       = n1_mag;
        num2       = n2_mag;
        info5.use1 = 1'b1;
        info5.use2 = 1'b1;
        info5.neg1 = (n1[NM] != na5) && (n1 != '0);
        info5.neg2 = (n2[NM] != na5) && (n2 != '0);
      end
      default: begin
        den = den2a;
      end
    endcase
  end

  logic           vld5_q;
  logic [NM-1:0]  num1_q, num2_q;
  logic [DNW-1:0] den_q;
  qrs_info_t      info5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld5_q <= 1'b0;
    end else begin
      vld5_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    num1_q  <= num1;
    num2_q  <= num2;
    den_q   <= den;
    info5_q <= info5;
  end

  // Scaled divisions, both lanes in step
  logic          dv_vld;
  logic [NW-1:0] quo1, quo2;
  qrs_info_t     dv_info;

  qrs_div #(
    .NW (NW),
    .DW (DNW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld5_q),
    .num1_i  (NW'(num1_q) << FRAC_BITS),
    .num2_i  (NW'(num2_q) << FRAC_BITS),
    .den_i   (den_q),
    .info_i  (info5_q),
    .valid_o (dv_vld),
    .quo1_o  (quo1),
    .quo2_o  (quo2),
    .info_o  (dv_info)
  );

  // Clip to the signed range and apply signs
  localparam logic [NW-1:0] POS_LIM = (NW'(1) << (W - 1)) - NW'(1);
  localparam logic [NW-1:0] NEG_LIM = NW'(1) << (W - 1);

  logic         sat1, sat2;
  logic [W-1:0] m1, m2, v1, v2;

  always_comb begin
    sat1 = quo1 > (dv_info.neg1 ? NEG_LIM : POS_LIM);
    sat2 = quo2 > (dv_info.neg2 ? NEG_LIM : POS_LIM);
    m1   = sat1 ? W'(dv_info.neg1 ? NEG_LIM : POS_LIM) : W'(quo1);
    m2   = sat2 ? W'(dv_info.neg2 ? NEG_LIM : POS_LIM) : W'(quo2);
    v1   = '0;
    v2   = '0;
    if (dv_info.use1) begin
      v1 = dv_info.neg1 ? W'(-m1) : m1;
    end
    if (dv_info.use2) begin
      v2 = dv_info.neg2 ? W'(-m2) : m2;
    end
  end

  // Output register
  logic         done_q, sat_q;
  root_case_e   rc_q;
  logic [W-1:0] v1_q, v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    rc_q  <= dv_info.rc;
    v1_q  <= v1;
    v2_q  <= v2;
    sat_q <= (dv_info.use1 && sat1) || (dv_info.use2 && sat2);
  end

  assign done_o         = done_q;
  assign root_case_o    = rc_q;
  assign first_value_o  = v1_q;
  assign second_value_o = v2_q;
  assign saturated_o    = sat_q;

endmodule

### bench/quadratic_root_solver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_test
// Self-checking bench for the quadratic root solver. Coefficient sets go in
// through start/busy. A scoreboard predicts each case code, both Q16.16 values
// and the saturation flag at full width, queues the prediction and compares
// every done beat with the oldest one. The stimulus is a directed set, then
// random sets in several sender idle phases.
// ----------------------------------------------------------------------------
module quadratic_root_solver_test
  import qrs_pkg::*;
();

  localparam int DW       = DATA_WIDTH_DEF;
  localparam int FB       = FRAC_BITS_DEF;
  localparam int N_RANDOM = 1800;
  localparam int WD_LIMIT = 2000;

  typedef struct {
    root_case_e    rc;
    logic [DW-1:0] first;
    logic [DW-1:0] second;
    logic          sat;
  } roots_t;

  class root_scoreboard;
    roots_t pending_roots[$];
    int     mismatches;
    int     n_checked;
    int     case_seen[6];

    // Apply the sign to a magnitude and clip it to the signed range
    function logic [DW-1:0] clip_signed(bit neg, logic [127:0] mag, inout bit sat);
      logic [127:0] lim;
      lim = neg ? (128'd1 << (DW - 1)) : ((128'd1 << (DW - 1)) - 1);
      if (mag > lim) begin
        sat = 1'b1;
        mag = lim;
      end
      return neg ? DW'(-mag) : DW'(mag);
    endfunction

    // trunc(sign * num * 2^FB / den)
    function logic [DW-1:0] fixed_quot(bit neg, logic [63:0] num, logic [63:0] den,
                                       inout bit sat);
      logic [127:0] q;
      q = ({64'd0, num} << FB) / {64'd0, den};
      return clip_signed(neg && q != 0, q, sat);
    endfunction

    function logic [63:0] isqrt(logic [127:0] d);
      logic [63:0] r, t;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
        t = r | (64'd1 << i);
        if ({64'd0, t} * {64'd0, t} <= d) r = t;
      end
      return r;
    endfunction

    function roots_t predict_roots(logic [DW-1:0] a, logic [DW-1:0] b, logic [DW-1:0] c);
      roots_t       res;
      bit           na, nb, nc, sat, dneg;
      logic [63:0]  ma, mb, mc, den, sq;
      logic [127:0] bsq, p4, dmag;
      longint       mbs, n1, n2;
      na = a[DW-1]; nb = b[DW-1]; nc = c[DW-1];
      ma = {32'd0, na ? DW'(-a) : a};
      mb = {32'd0, nb ? DW'(-b) : b};
      mc = {32'd0, nc ? DW'(-c) : c};
      sat = 0; dneg = 0;
      res.first = '0; res.second = '0;
      if (ma == 0) begin
        if (mb == 0) res.rc = (mc == 0) ? RC_INDET : RC_NONE;
        else begin
          res.rc = RC_LINEAR;
          res.first = fixed_quot((nc == nb) && mc != 0, mc, mb, sat);
        end
      end else begin
        bsq = {64'd0, mb} * {64'd0, mb};
        p4  = ({64'd0, ma} * {64'd0, mc}) << 2;
        den = ma << 1;
        if (na == nc && mc != 0) begin
          if (bsq >= p4) dmag = bsq - p4;
          else begin
            dmag = p4 - bsq;
            dneg = 1;
          end
        end else dmag = bsq + p4;
        if (dmag == 0) begin
          res.rc = RC_DOUBLE;
          res.first = fixed_quot((!nb) != na && mb != 0, mb, den, sat);
        end else if (!dneg) begin
          res.rc = RC_TWO_REAL;
          sq  = isqrt(dmag);
          mbs = nb ? longint'(mb) : -longint'(mb);
          n1  = mbs + longint'(sq);
          n2  = mbs - longint'(sq);
          res.first  = fixed_quot((n1 < 0) != na && n1 != 0,
                                  n1 < 0 ? -n1 : n1, den, sat);
          res.second = fixed_quot((n2 < 0) != na && n2 != 0,
                                  n2 < 0 ? -n2 : n2, den, sat);
        end else begin
          res.rc = RC_COMPLEX;
          res.first  = fixed_quot((!nb) != na && mb != 0, mb, den, sat);
          res.second = fixed_quot(0, isqrt(dmag), den, sat);
        end
      end
      res.sat = sat;
      return res;
    endfunction

    // Note an accepted coefficient beat
    function void note_coefs(logic [DW-1:0] a, logic [DW-1:0] b, logic [DW-1:0] c);
      roots_t r;
      r = predict_roots(a, b, c);
      case_seen[r.rc]++;
      pending_roots.push_back(r);
    endfunction

    // Compare a result beat with the oldest prediction
    function void check_roots(roots_t got);
      roots_t exp_r;
      n_checked++;
      if (pending_roots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: case %0d", got.rc);
        return;
      end
      exp_r = pending_roots.pop_front();
      if (got.rc !== exp_r.rc || got.first !== exp_r.first ||
          got.second !== exp_r.second || got.sat !== exp_r.sat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp case %0d %h %h sat %b, got case %0d %h %h sat %b",
                   exp_r.rc, exp_r.first, exp_r.second, exp_r.sat,
                   got.rc, got.first, got.second, got.sat);
      end
    endfunction
  endclass

  logic          clk_i = 0;
  logic          rst_ni = 0;
  logic          start_i = 0;
  logic [DW-1:0] coef_a_i = '0, coef_b_i = '0, coef_c_i = '0;
  logic          busy_o, done_o, saturated_o;
  logic [2:0]    root_case_o;
  logic [DW-1:0] first_value_o, second_value_o;

  root_scoreboard sb = new();
  int idle_pct;
  int quiet_cycles;
  roots_t got;

  quadratic_root_solver dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .coef_a_i, .coef_b_i, .coef_c_i,
    .done_o, .root_case_o, .first_value_o, .second_value_o, .saturated_o
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // Check result beats; count cycles with no beat moving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        got.rc = root_case_e'(root_case_o);
        got.first = first_value_o;
        got.second = second_value_o;
        got.sat = saturated_o;
        sb.check_roots(got);
      end
      if (done_o || (start_i && !busy_o)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog
  initial begin
    quiet_cycles = 0;
    wait (quiet_cycles >= WD_LIMIT);
    $display("watchdog expired");
    $display("TB_ERROR");
    $finish;
  end

  // Present one coefficient beat, hold until taken, then maybe idle
  task automatic send_coefs(logic [DW-1:0] a, logic [DW-1:0] b, logic [DW-1:0] c);
    start_i  <= 1'b1;
    coef_a_i <= a;
    coef_b_i <= b;
    coef_c_i <= c;
    do @(posedge clk_i); while (busy_o);
    sb.note_coefs(a, b, c);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
  endtask

  function automatic logic [DW-1:0] rand_coef();
    case ($urandom_range(5))
      0:       return $urandom;
      1:       return '0;
      2:       return DW'($signed($urandom_range(16'hFFFF) << 4) >>> 2);
      3:       return $urandom_range(1) ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      default: return DW'($signed(20'($urandom)));
    endcase
  endfunction

  // Coefficients with b^2 = 4ac exactly: a and c share a sign, 2pq stays in range
  task automatic send_double();
    logic [DW-1:0] p, q;
    bit            neg_ac;
    p = $urandom_range(46340, 1);
    q = $urandom_range(23170, 0);
    neg_ac = 1'($urandom_range(1));
    send_coefs(neg_ac ? -(p * p) : p * p,
               $urandom_range(1) ? 2 * p * q : -(2 * p * q),
               neg_ac ? -(q * q) : q * q);
  endtask

  initial begin
    idle_pct = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every case, the field extremes, saturation
    send_coefs(0, 0, 0);
    send_coefs(0, 0, 32'h0001_0000);
    send_coefs(0, 32'h0002_0000, 32'h0001_0000);
    send_coefs(0, 32'h0000_0001, 32'h7FFF_FFFF);
    send_coefs(0, 32'hFFFF_FFFF, 32'h8000_0000);
    send_coefs(32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000);
    send_coefs(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
    send_coefs(32'h0001_0000, 0, 32'h0001_0000);
    send_coefs(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000);
    send_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_coefs(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_coefs(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
    send_coefs(32'h0000_0001, 0, 32'h7FFF_FFFF);
    send_coefs(32'hFFFF_FFFF, 32'h8000_0000, 0);
    send_coefs(32'h0000_0001, 32'h0000_0002, 32'h0000_0001);
    send_coefs(32'h0000_0001, 32'hFFFF_FFFF, 0);
    send_coefs(32'h7FFF_FFFF, 0, 0);

    // Random phases: no idling, heavy sender idling, light sender idling
    for (int n = 0; n < N_RANDOM; n++) begin
      idle_pct = (n < 600) ? 0 : (n < 1200) ? 67 : 12;
      if (n == 900) begin
        // Hold off until the pipeline drains
        start_i <= 1'b0;
        while (sb.pending_roots.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
      if ($urandom_range(9) == 0) send_double();
      else send_coefs(rand_coef(), rand_coef(), rand_coef());
    end
    start_i <= 1'b0;

    while (sb.pending_roots.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("checked %0d results: indet %0d none %0d linear %0d two-real %0d",
             sb.n_checked, sb.case_seen[0], sb.case_seen[1], sb.case_seen[2],
             sb.case_seen[3]);
    $display("double %0d complex %0d, mismatches %0d",
             sb.case_seen[4], sb.case_seen[5], sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_roots.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
